FILE: rtl/vanu_pkg.sv
package vanu_pkg;

  localparam int unsigned FracBitsDef = 16;

  typedef enum logic [2:0] {
    FUNC_ADD   = 3'd0,
    FUNC_SUB   = 3'd1,
    FUNC_SCALE = 3'd2,
    FUNC_MAG   = 3'd3,
    FUNC_NORM  = 3'd4,
    FUNC_EQ    = 3'd5
  } func_e;

  typedef logic [3:0][31:0] vec_t;

  // clamp a 33-bit signed sum to the 32-bit signed range
  function automatic logic [31:0] sat33(input logic [32:0] x);
    logic [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/vector4_arith_normalize_unit.sv
// fixed point with FRAC_BITS fraction bits, Q16.16 at the default
// throughput: one request per cycle, busy is never raised
// depth is set by the 32-stage square root and the FRAC_BITS+1 stage dividers
// the receiver cannot stall; each result is valid only in the cycle done_o is high
// reset clears all valid bits asynchronously; data registers are not reset
module vector4_arith_normalize_unit import vanu_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [31:0] a_i_i,
  input  logic [31:0] a_j_i,
  input  logic [31:0] a_k_i,
  input  logic [31:0] a_l_i,
  input  logic [31:0] b_i_i,
  input  logic [31:0] b_j_i,
  input  logic [31:0] b_k_i,
  input  logic [31:0] b_l_i,
  input  logic [31:0] scalar_i,
  output logic        done_o,
  output logic [31:0] r_i_o,
  output logic [31:0] r_j_o,
  output logic [31:0] r_k_o,
  output logic [31:0] r_l_o,
  output logic [30:0] length_o,
  output logic        equal_o,
  output logic        zero_length_o
);

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned RW = FRAC_BITS + 34;
  localparam int unsigned SQS = 32;

  typedef struct packed {
    func_e      func;
    vec_t       res;
    logic       eq;
    vec_t       mag;
    logic [3:0] neg;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic        ovf;
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
  } sqs_t;

  typedef struct packed {
    side_t                side;
    logic [30:0]          len;
    logic                 zl;
    logic [32:0]          m;
    logic [3:0][RW-1:0]   rem;
    logic [3:0][QW-1:0]   q;
  } dvs_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // stage a: request capture
  logic  va_q;
  func_e fa_q;
  vec_t  a_q, b_q;
  logic [31:0] s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    fa_q <= func_e'(func_i);
    a_q  <= {a_l_i, a_k_i, a_j_i, a_i_i};
    b_q  <= {b_l_i, b_k_i, b_j_i, b_i_i};
    s_q  <= scalar_i;
  end

  // stage b: squares, scale products, add/sub/equal
  side_t side_b_d, side_b_q;
  logic  vb_q;
  logic [63:0] sq_d [4];
  logic [63:0] sq_q [4];
  logic [63:0] prod_d [4];
  logic [63:0] prod_q [4];

  always_comb begin
    side_b_d.func = fa_q;
    side_b_d.eq   = (fa_q == FUNC_EQ) && (a_q == b_q);
    for (int c = 0; c < 4; c++) begin
      side_b_d.neg[c] = a_q[c][31];
      side_b_d.mag[c] = a_q[c][31] ? (~a_q[c] + 32'd1) : a_q[c];
      sq_d[c]   = side_b_d.mag[c] * side_b_d.mag[c];
      prod_d[c] = $signed(a_q[c]) * $signed(s_q);
      unique case (fa_q)
        FUNC_ADD: side_b_d.res[c] = sat33({a_q[c][31], a_q[c]} + {b_q[c][31], b_q[c]});
        FUNC_SUB: side_b_d.res[c] = sat33({a_q[c][31], a_q[c]} - {b_q[c][31], b_q[c]});
        default:  side_b_d.res[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_b_q <= side_b_d;
    sq_q     <= sq_d;
    prod_q   <= prod_d;
  end

  // stage c: pair sums, scale rounding and clamp
  side_t side_c_d, side_c_q;
  logic  vc_q;
  logic [64:0] ps_d [2];
  logic [64:0] ps_q [2];
  logic [65:0] scl_x [4];
  logic [65:0] scl_s [4];
  logic [31:0] scl_r [4];

  always_comb begin
    side_c_d = side_b_q;
    ps_d[0]  = {1'b0, sq_q[0]} + {1'b0, sq_q[1]};
    ps_d[1]  = {1'b0, sq_q[2]} + {1'b0, sq_q[3]};
    for (int c = 0; c < 4; c++) begin
      scl_x[c] = {{2{prod_q[c][63]}}, prod_q[c]} + (66'd1 << (FRAC_BITS - 1));
      scl_s[c] = 66'($signed(scl_x[c]) >>> FRAC_BITS);
      if ((&scl_s[c][65:31]) || !(|scl_s[c][65:31])) begin
        scl_r[c] = scl_s[c][31:0];
      end else begin
        scl_r[c] = scl_s[c][65] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      if (side_b_q.func == FUNC_SCALE) begin
        side_c_d.res[c] = scl_r[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_c_q <= side_c_d;
    ps_q     <= ps_d;
  end

  // stage d and square root pipeline, two radicand bits per stage
  sqs_t sqp_d [SQS+1];
  sqs_t sqp_q [SQS+1];
  logic sqv_q [SQS+1];
  logic [65:0] tot;

  always_comb begin
    tot = {1'b0, ps_q[0]} + {1'b0, ps_q[1]};
    sqp_d[0].side = side_c_q;
    sqp_d[0].ovf  = |tot[65:64];
    sqp_d[0].rad  = tot[63:0];
    sqp_d[0].rem  = '0;
    sqp_d[0].root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqv_q[0] <= 1'b0;
    end else begin
      sqv_q[0] <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqp_q[0] <= sqp_d[0];
  end

  for (genvar k = 1; k <= SQS; k++) begin : g_sqrt
    logic [34:0] rem2;
    logic [34:0] trial;

    always_comb begin
      sqp_d[k]     = sqp_q[k-1];
      rem2         = {sqp_q[k-1].rem[32:0], sqp_q[k-1].rad[63:62]};
      trial        = {1'b0, sqp_q[k-1].root, 2'b01};
      sqp_d[k].rad = {sqp_q[k-1].rad[61:0], 2'b00};
      if (rem2 >= trial) begin
        sqp_d[k].rem  = rem2 - trial;
        sqp_d[k].root = {sqp_q[k-1].root[30:0], 1'b1};
      end else begin
        sqp_d[k].rem  = rem2;
        sqp_d[k].root = {sqp_q[k-1].root[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[k] <= 1'b0;
      end else begin
        sqv_q[k] <= sqv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      sqp_q[k] <= sqp_d[k];
    end
  end

  // stage e and restoring dividers, one quotient bit per stage
  dvs_t dvp_d [QW+1];
  dvs_t dvp_q [QW+1];
  logic dvv_q [QW+1];

  always_comb begin
    dvp_d[0].side = sqp_q[SQS].side;
    dvp_d[0].m    = sqp_q[SQS].ovf ? 33'h1_0000_0000 : {1'b0, sqp_q[SQS].root};
    dvp_d[0].len  = (sqp_q[SQS].ovf || sqp_q[SQS].root[31]) ? 31'h7fff_ffff
                                                              : sqp_q[SQS].root[30:0];
    dvp_d[0].zl   = (sqp_q[SQS].side.func == FUNC_NORM) && (dvp_d[0].m == 33'd0);
    dvp_d[0].q    = '0;
    for (int c = 0; c < 4; c++) begin
      dvp_d[0].rem[c] = RW'({sqp_q[SQS].side.mag[c], {FRAC_BITS{1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else begin
      dvv_q[0] <= sqv_q[SQS];
    end
  end

  always_ff @(posedge clk_i) begin
    dvp_q[0] <= dvp_d[0];
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int unsigned P = QW - k;
    logic [RW-1:0] dsh;

    always_comb begin
      dvp_d[k] = dvp_q[k-1];
      dsh      = RW'(dvp_q[k-1].m) << P;
      for (int c = 0; c < 4; c++) begin
        if (dvp_q[k-1].rem[c] >= dsh) begin
          dvp_d[k].rem[c]  = dvp_q[k-1].rem[c] - dsh;
          dvp_d[k].q[c][P] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k] <= 1'b0;
      end else begin
        dvv_q[k] <= dvv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dvp_q[k] <= dvp_d[k];
    end
  end

  // output register
  dvs_t fin;
  vec_t r_d, r_q;
  logic [30:0] len_d, len_q;
  logic eq_q, zl_q, done_q;
  logic [31:0] qx [4];

  assign fin = dvp_q[QW];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      qx[c] = 32'(fin.q[c]);
      if (fin.side.func == FUNC_NORM) begin
        r_d[c] = fin.zl ? 32'd0 : (fin.side.neg[c] ? (~qx[c] + 32'd1) : qx[c]);
      end else begin
        r_d[c] = fin.side.res[c];
      end
    end
    len_d = ((fin.side.func == FUNC_MAG) || (fin.side.func == FUNC_NORM)) ? fin.len : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dvv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    len_q <= len_d;
    eq_q  <= fin.side.eq;
    zl_q  <= fin.zl;
  end

  assign done_o        = done_q;
  assign r_i_o         = r_q[0];
  assign r_j_o         = r_q[1];
  assign r_k_o         = r_q[2];
  assign r_l_o         = r_q[3];
  assign length_o      = len_q;
  assign equal_o       = eq_q;
  assign zero_length_o = zl_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({equal_o, zero_length_o}))
    else $error("equal and zero_length both set");

  a_zero_len_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_length_o) |-> (r_q == '0) && (length_o == '0))
    else $error("zero-length normalize with nonzero result");

  a_equal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && equal_o) |-> (r_q == '0) && (length_o == '0))
    else $error("equal result with nonzero vector or length");

  a_done_follows_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvv_q[QW] |=> done_o)
    else $error("divider output lost before output register");

endmodule

FILE: test/vector4_arith_normalize_unit_tb.sv
module vector4_arith_normalize_unit_tb;
  import vanu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits = FracBitsDef;
  localparam int unsigned DoneLatency = FracBits + 38;
  localparam int unsigned StallLimit = 2000;
  localparam logic [2:0] FuncRsvd6 = 3'd6;
  localparam logic [2:0] FuncRsvd7 = 3'd7;
  localparam logic [31:0] SMax = 32'h7fff_ffff;
  localparam logic [31:0] SMin = 32'h8000_0000;

  typedef struct {
    logic [3:0][31:0] r;
    logic [30:0] len;
    logic eq;
    logic zl;
  } vec_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func_i = '0;
  logic [31:0] a_i_i = '0, a_j_i = '0, a_k_i = '0, a_l_i = '0;
  logic [31:0] b_i_i = '0, b_j_i = '0, b_k_i = '0, b_l_i = '0;
  logic [31:0] scalar_i = '0;
  logic done_o;
  logic [31:0] r_i_o, r_j_o, r_k_o, r_l_o;
  logic [30:0] length_o;
  logic equal_o, zero_length_o;

  vec_result_t expected_q[$];
  int unsigned n_errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned idle_pct = 0;

  always #5 clk_i = ~clk_i;

  vector4_arith_normalize_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .func_i,
    .a_i_i, .a_j_i, .a_k_i, .a_l_i, .b_i_i, .b_j_i, .b_k_i, .b_l_i, .scalar_i,
    .done_o, .r_i_o, .r_j_o, .r_k_o, .r_l_o, .length_o, .equal_o, .zero_length_o
  );

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint sat_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic vec_result_t vector_op(logic [2:0] f, logic [3:0][31:0] a,
                                            logic [3:0][31:0] b, logic [31:0] s);
    vec_result_t res;
    longint sa, sb, ss;
    longint unsigned mag, m, q;
    logic [65:0] sum;
    res.r = '0;
    res.len = '0;
    res.eq = 1'b0;
    res.zl = 1'b0;
    ss = longint'(signed'(s));
    case (f)
      FUNC_ADD, FUNC_SUB, FUNC_SCALE: begin
        for (int c = 0; c < 4; c++) begin
          sa = longint'(signed'(a[c]));
          sb = longint'(signed'(b[c]));
          if (f == FUNC_ADD) res.r[c] = 32'(sat_s32(sa + sb));
          else if (f == FUNC_SUB) res.r[c] = 32'(sat_s32(sa - sb));
          else res.r[c] = 32'(sat_s32((sa * ss + (64'sd1 << (FracBits - 1))) >>> FracBits));
        end
      end
      FUNC_MAG, FUNC_NORM: begin
        sum = '0;
        for (int c = 0; c < 4; c++) begin
          sa = longint'(signed'(a[c]));
          mag = longint'(sa < 0 ? -sa : sa);
          sum += 66'(mag * mag);
        end
        m = sum[65:64] != 0 ? 64'd1 << 32 : int_sqrt(sum[63:0]);
        res.len = m > 64'h7fff_ffff ? 31'h7fff_ffff : 31'(m);
        if (f == FUNC_NORM) begin
          if (m == 0) begin
            res.zl = 1'b1;
          end else begin
            for (int c = 0; c < 4; c++) begin
              sa = longint'(signed'(a[c]));
              mag = longint'(sa < 0 ? -sa : sa);
              q = (mag << FracBits) / m;
              res.r[c] = sa < 0 ? 32'(-longint'(q)) : 32'(q);
            end
          end
        end
      end
      FUNC_EQ: res.eq = (a == b);
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    n_errors++;
  endtask

  task automatic send_request(logic [2:0] f, logic [3:0][31:0] a, logic [3:0][31:0] b,
                              logic [31:0] s);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    func_i <= f;
    {a_l_i, a_k_i, a_j_i, a_i_i} <= a;
    {b_l_i, b_k_i, b_j_i, b_i_i} <= b;
    scalar_i <= s;
    do @(posedge clk_i); while (busy);
    expected_q.push_back(vector_op(f, a, b, s));
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom_range(3) == 0 ? SMax : SMin;
      1: return 32'(signed'($urandom_range(8)) - 4);
      2: return 32'(signed'($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    logic [3:0][31:0] z, mx, mn, one;
    z = '0;
    mx = {4{SMax}};
    mn = {4{SMin}};
    one = {32'h0, 32'h0, 32'h0, 32'h0001_0000};
    send_request(FUNC_ADD, mx, mx, '0);
    send_request(FUNC_ADD, mn, mn, '0);
    send_request(FUNC_ADD, mx, mn, '0);
    send_request(FUNC_SUB, mn, mx, '0);
    send_request(FUNC_SUB, mx, mn, '0);
    send_request(FUNC_SCALE, mx, z, SMax);
    send_request(FUNC_SCALE, mn, z, SMin);
    send_request(FUNC_SCALE, mx, z, SMin);
    send_request(FUNC_SCALE, {32'hffff_ffff, 32'h1, 32'h8000, 32'hffff_8000}, z, 32'h0001_0000);
    send_request(FUNC_MAG, mx, z, '0);
    send_request(FUNC_MAG, mn, z, '0);
    send_request(FUNC_MAG, {32'h0, 32'h0, 32'h0, SMin}, z, '0);
    send_request(FUNC_MAG, z, z, '0);
    send_request(FUNC_MAG, {32'h0004_0000, 32'h0, 32'h0, 32'h0003_0000}, z, '0);
    send_request(FUNC_NORM, z, z, '0);
    send_request(FUNC_NORM, one, z, '0);
    send_request(FUNC_NORM, mn, z, '0);
    send_request(FUNC_NORM, mx, z, '0);
    send_request(FUNC_NORM, {32'h0, 32'h0, 32'h1, 32'hffff_ffff}, z, '0);
    send_request(FUNC_EQ, mx, mx, '0);
    send_request(FUNC_EQ, mx, {SMax, SMax, SMax, 32'h7fff_fffe}, '0);
    send_request(FUNC_EQ, z, z, '0);
    send_request(FuncRsvd6, mx, mn, SMax);
    send_request(FuncRsvd7, mn, mx, SMin);
  endtask

  task automatic test_random(int unsigned n, int unsigned pct);
    logic [3:0][31:0] a, b;
    logic [2:0] f;
    idle_pct = pct;
    for (int unsigned i = 0; i < n; i++) begin
      f = $urandom_range(15) == 0 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      for (int c = 0; c < 4; c++) begin
        a[c] = rand_word();
        b[c] = rand_word();
      end
      if (f == FUNC_EQ && $urandom_range(1)) begin
        b = a;
        if ($urandom_range(1)) b[$urandom_range(3)][$urandom_range(31)] ^= 1'b1;
      end
      if (f == FUNC_NORM && $urandom_range(9) == 0) a = '0;
      send_request(f, a, b, rand_word());
    end
  endtask

  always @(posedge clk_i) begin
    vec_result_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_q.pop_front();
        if (r_i_o !== want.r[0]) report_mismatch("r_i", r_i_o, want.r[0]);
        if (r_j_o !== want.r[1]) report_mismatch("r_j", r_j_o, want.r[1]);
        if (r_k_o !== want.r[2]) report_mismatch("r_k", r_k_o, want.r[2]);
        if (r_l_o !== want.r[3]) report_mismatch("r_l", r_l_o, want.r[3]);
        if (length_o !== want.len) report_mismatch("length", length_o, want.len);
        if (equal_o !== want.eq) report_mismatch("equal", equal_o, want.eq);
        if (zero_length_o !== want.zl) report_mismatch("zero_length", zero_length_o, want.zl);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(150, 0);
    test_random(130, 76);
    test_random(120, 23);
    test_random(130, 0);
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DoneLatency + 10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
